>>> rtl/core/fwdm_pkg.sv
package fwdm_pkg;

    // Stream and storage defaults
    localparam int AXIS_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed point: 1.0 is 2**FRAC_BITS
    localparam int FRAC_BITS = 14;
    localparam int UNIT_ONE  = 16384;

    // Internal widths
    localparam int UNIT_W     = 16;  // clamped axis or final unit value
    localparam int MIX_W      = 17;  // sums of up to three unit values
    localparam int MAG_W      = 16;  // magnitude of a mixed value, up to 2.0
    localparam int QUO_W      = 15;  // desaturation quotient, up to 1.0
    localparam int DIV_STAGES = QUO_W;
    localparam int CMD_W      = 15;
    localparam int NUM_CMDS   = 4;
    localparam int OUT_TDATA_W = ((NUM_CMDS * CMD_W + 7) / 8) * 8;

    // Configuration registers
    localparam int MODE_W     = 2;
    localparam int DEADBAND_W = 15;
    localparam int MAX_OUT_W  = 14;
    localparam int PROD_W     = UNIT_W + MAX_OUT_W + 1;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = '0;
    localparam logic [MAX_OUT_W-1:0]  MAX_OUT_RESET  = 14'd12000;

    // Command kind flag
    localparam logic KIND_VELOCITY = 1'b0;
    localparam logic KIND_VOLTAGE  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TANK      = 2'd0,
        MODE_ARCADE    = 2'd1,
        MODE_VECTOR    = 2'd2,
        MODE_HOLONOMIC = 2'd3
    } t_drive_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DRIVE_MODE = 2'd0,
        REG_DEADBAND   = 2'd1,
        REG_MAX_OUTPUT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_drive_mode             mode;
        logic [DEADBAND_W-1:0]   deadband;
        logic [MAX_OUT_W-1:0]    max_output;
    } t_cfg;

    // One mixed item as it travels from the front to the back
    typedef struct packed {
        logic signed [MIX_W-1:0] fl;
        logic signed [MIX_W-1:0] fr;
        logic signed [MIX_W-1:0] rr;
        logic signed [MIX_W-1:0] rl;
        logic                    kind;
        logic                    desat;    // vector pair needs scaling down
        logic                    l_major;  // left magnitude is the larger one
        logic [MAG_W-1:0]        num;      // smaller magnitude
        logic [MAG_W-1:0]        den;      // larger magnitude
    } t_mix_item;

endpackage

>>> rtl/core/fwdm_front.sv
module fwdm_front #(
    parameter int AXIS_WIDTH = fwdm_pkg::AXIS_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fwdm_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [AXIS_WIDTH-1:0] i_strafe_axis,
    input  logic signed [AXIS_WIDTH-1:0] i_forward_axis,
    input  logic signed [AXIS_WIDTH-1:0] i_turn_axis,
    input  logic signed [AXIS_WIDTH-1:0] i_left_stick,
    input  logic signed [AXIS_WIDTH-1:0] i_right_stick,
    input  logic                         i_q_full,
    output logic                         o_push,
    output fwdm_pkg::t_mix_item          o_item
);

    localparam int UNIT_W = fwdm_pkg::UNIT_W;
    localparam int MIX_W  = fwdm_pkg::MIX_W;
    localparam int MAG_W  = fwdm_pkg::MAG_W;
    localparam int EXT_W  = (AXIS_WIDTH > MIX_W) ? AXIS_WIDTH : MIX_W;

    typedef struct packed {
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] z;
        logic signed [UNIT_W-1:0] lt;
        logic signed [UNIT_W-1:0] rt;
    } t_axes;

    function automatic logic signed [UNIT_W-1:0] clamp_axis(
        input logic signed [AXIS_WIDTH-1:0] v
    );
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > EXT_W'(fwdm_pkg::UNIT_ONE)) begin
            e = EXT_W'(fwdm_pkg::UNIT_ONE);
        end else if (e < EXT_W'(-fwdm_pkg::UNIT_ONE)) begin
            e = EXT_W'(-fwdm_pkg::UNIT_ONE);
        end
        return UNIT_W'(e);
    endfunction

    function automatic logic signed [UNIT_W-1:0] deadband_axis(
        input logic signed [UNIT_W-1:0]          v,
        input logic                              use_db,
        input logic [fwdm_pkg::DEADBAND_W-1:0]   db
    );
        logic signed [UNIT_W-1:0] neg;
        logic [UNIT_W-1:0]        mag;
        neg = -v;
        mag = v[UNIT_W-1] ? neg : v;
        if (use_db && (mag < UNIT_W'(db))) begin
            return '0;
        end
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] abs_mix(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] neg;
        neg = -v;
        return v[MIX_W-1] ? MAG_W'(neg) : MAG_W'(v);
    endfunction

    function automatic logic signed [MIX_W-1:0] clamp_mix(input logic signed [MIX_W-1:0] v);
        if (v > MIX_W'(fwdm_pkg::UNIT_ONE)) begin
            return MIX_W'(fwdm_pkg::UNIT_ONE);
        end
        if (v < MIX_W'(-fwdm_pkg::UNIT_ONE)) begin
            return MIX_W'(-fwdm_pkg::UNIT_ONE);
        end
        return v;
    endfunction

    logic                r_f1_valid;
    logic                r_f2_valid;
    t_axes               r_f1;
    t_axes               n_f1;
    fwdm_pkg::t_mix_item r_f2;
    fwdm_pkg::t_mix_item n_f2;
    logic                use_db;

    logic signed [MIX_W-1:0] x;
    logic signed [MIX_W-1:0] y;
    logic signed [MIX_W-1:0] z;
    logic signed [MIX_W-1:0] sum_l;
    logic signed [MIX_W-1:0] sum_r;
    logic signed [MIX_W-1:0] m;
    logic [MAG_W-1:0]        mag_a;
    logic [MAG_W-1:0]        mag_b;
    logic [MAG_W-1:0]        big;
    logic                    same_sign;
    logic                    l_major;

    // Stall the front only when the queue cannot take the finished item
    assign o_ready = !r_f2_valid || !i_q_full;
    assign o_push  = r_f2_valid && !i_q_full;
    assign o_item  = r_f2;

    // Stage 1: clamp every axis, then apply the deadband outside vector mode
    always_comb begin
        use_db  = (i_cfg.mode != fwdm_pkg::MODE_VECTOR);
        n_f1.x  = deadband_axis(clamp_axis(i_strafe_axis), use_db, i_cfg.deadband);
        n_f1.y  = deadband_axis(clamp_axis(i_forward_axis), use_db, i_cfg.deadband);
        n_f1.z  = deadband_axis(clamp_axis(i_turn_axis), use_db, i_cfg.deadband);
        n_f1.lt = deadband_axis(clamp_axis(i_left_stick), use_db, i_cfg.deadband);
        n_f1.rt = deadband_axis(clamp_axis(i_right_stick), use_db, i_cfg.deadband);
    end

    // Stage 2: mix the axes by drive mode
    always_comb begin
        x         = MIX_W'(r_f1.x);
        y         = MIX_W'(r_f1.y);
        z         = MIX_W'(r_f1.z);
        sum_l     = y + z;
        sum_r     = y - z;
        same_sign = (y[MIX_W-1] == z[MIX_W-1]);
        mag_a     = '0;
        mag_b     = '0;
        big       = '0;
        m         = '0;
        l_major   = 1'b0;
        n_f2      = '0;
        n_f2.kind = fwdm_pkg::KIND_VOLTAGE;
        case (i_cfg.mode)
            fwdm_pkg::MODE_TANK: begin
                n_f2.fl = MIX_W'(r_f1.lt);
                n_f2.rl = MIX_W'(r_f1.lt);
                n_f2.fr = MIX_W'(r_f1.rt);
                n_f2.rr = MIX_W'(r_f1.rt);
            end
            fwdm_pkg::MODE_ARCADE: begin
                mag_a = abs_mix(y);
                mag_b = abs_mix(z);
                big   = (mag_a > mag_b) ? mag_a : mag_b;
                m     = $signed(MIX_W'(big));
                if (y[MIX_W-1]) begin
                    m = -m;
                end
                n_f2.fl = clamp_mix(same_sign ? m : sum_l);
                n_f2.fr = clamp_mix(same_sign ? sum_r : m);
                n_f2.rr = n_f2.fr;
                n_f2.rl = n_f2.fl;
            end
            fwdm_pkg::MODE_VECTOR: begin
                mag_a        = abs_mix(sum_l);
                mag_b        = abs_mix(sum_r);
                l_major      = (mag_a >= mag_b);
                big          = l_major ? mag_a : mag_b;
                n_f2.fl      = sum_l;
                n_f2.rl      = sum_l;
                n_f2.fr      = sum_r;
                n_f2.rr      = sum_r;
                n_f2.kind    = fwdm_pkg::KIND_VELOCITY;
                n_f2.desat   = (big > MAG_W'(fwdm_pkg::UNIT_ONE));
                n_f2.l_major = l_major;
                n_f2.num     = l_major ? mag_b : mag_a;
                n_f2.den     = big;
            end
            fwdm_pkg::MODE_HOLONOMIC: begin
                n_f2.fl = clamp_mix(y + x + z);
                n_f2.fr = clamp_mix(y - x - z);
                n_f2.rr = clamp_mix(y + x - z);
                n_f2.rl = clamp_mix(y - x + z);
            end
            default: begin
                n_f2.kind = fwdm_pkg::KIND_VOLTAGE;
            end
        endcase
    end

    // Advance both front stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (o_ready) begin
            r_f1_valid <= i_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

    // Only vector mode asks for desaturation
    a_desat_is_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f2_valid && r_f2.desat |-> r_f2.kind == fwdm_pkg::KIND_VELOCITY)
        else $error("desaturation flagged on a voltage command");

endmodule

>>> rtl/core/fwdm_queue.sv
module fwdm_queue #(
    parameter int DEPTH = fwdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fwdm_pkg::t_mix_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output fwdm_pkg::t_mix_item o_item
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [PTR_W:0]      r_wr_ptr;
    logic [PTR_W:0]      r_rd_ptr;
    fwdm_pkg::t_mix_item r_mem [DEPTH];

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]) &&
                     (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_item  = r_mem[r_rd_ptr[PTR_W-1:0]];

    // Advance pointers on push and pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_item;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> !o_empty)
        else $error("queue empty after a push without pop");

endmodule

>>> rtl/core/fwdm_back.sv
module fwdm_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [fwdm_pkg::MAX_OUT_W-1:0]       i_max_output,
    input  logic                                 i_q_empty,
    input  fwdm_pkg::t_mix_item                  i_item,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [fwdm_pkg::CMD_W-1:0]           o_fl,
    output logic [fwdm_pkg::CMD_W-1:0]           o_fr,
    output logic [fwdm_pkg::CMD_W-1:0]           o_rr,
    output logic [fwdm_pkg::CMD_W-1:0]           o_rl,
    output logic                                 o_kind
);

    localparam int STAGES  = fwdm_pkg::DIV_STAGES;
    localparam int QUO_W   = fwdm_pkg::QUO_W;
    localparam int MAG_W   = fwdm_pkg::MAG_W;
    localparam int UNIT_W  = fwdm_pkg::UNIT_W;
    localparam int CMD_W   = fwdm_pkg::CMD_W;
    localparam int PROD_W  = fwdm_pkg::PROD_W;
    localparam int MO_W    = fwdm_pkg::MAX_OUT_W;
    localparam logic [QUO_W-1:0] TOP_BIT = {1'b1, {(QUO_W-1){1'b0}}};

    typedef struct packed {
        fwdm_pkg::t_mix_item item;
        logic [MAG_W-1:0]    rem;
        logic [QUO_W-1:0]    quo;
    } t_div_stage;

    // One restoring step: one quotient bit
    function automatic t_div_stage div_step(
        input t_div_stage       cur,
        input logic [MAG_W:0]   trial,
        input logic [QUO_W-1:0] bit_mask
    );
        t_div_stage     nxt;
        logic [MAG_W:0] den;
        nxt = cur;
        den = {1'b0, cur.item.den};
        if (trial >= den) begin
            nxt.quo = cur.quo | bit_mask;
            nxt.rem = MAG_W'(trial - den);
        end else begin
            nxt.rem = MAG_W'(trial);
        end
        return nxt;
    endfunction

    function automatic logic [CMD_W-1:0] scale_cmd(
        input logic signed [UNIT_W-1:0] u,
        input logic [MO_W-1:0]          mo
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(u) * $signed({1'b0, mo});
        return p[fwdm_pkg::FRAC_BITS +: CMD_W];
    endfunction

    logic                     back_en;
    logic [STAGES-1:0]        r_vld;
    t_div_stage               r_stg [STAGES];
    t_div_stage               n_stg [STAGES];
    t_div_stage               first;
    t_div_stage               last;

    logic signed [UNIT_W-1:0] one;
    logic signed [UNIT_W-1:0] qv;
    logic signed [UNIT_W-1:0] mag_l;
    logic signed [UNIT_W-1:0] mag_r;
    logic signed [UNIT_W-1:0] u_l;
    logic signed [UNIT_W-1:0] u_r;
    logic signed [UNIT_W-1:0] u_fl;
    logic signed [UNIT_W-1:0] u_fr;
    logic signed [UNIT_W-1:0] u_rr;
    logic signed [UNIT_W-1:0] u_rl;

    logic                     r_out_valid;
    logic [CMD_W-1:0]         r_fl;
    logic [CMD_W-1:0]         r_fr;
    logic [CMD_W-1:0]         r_rr;
    logic [CMD_W-1:0]         r_rl;
    logic                     r_kind;

    // The whole back moves when the output register is free or drained
    assign back_en = !r_out_valid || i_ready;
    assign o_pop   = back_en && !i_q_empty;

    // Divider stages: quotient bits from the top down
    always_comb begin
        first      = '0;
        first.item = i_item;
        n_stg[0]   = div_step(first, {1'b0, i_item.num}, TOP_BIT);
        for (int k = 1; k < STAGES; k++) begin
            n_stg[k] = div_step(r_stg[k-1], {r_stg[k-1].rem, 1'b0}, TOP_BIT >> k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (back_en) begin
            r_vld <= {r_vld[STAGES-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            for (int k = 0; k < STAGES; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Unit values: when desat, the larger side is full scale and the other the quotient
    always_comb begin
        last  = r_stg[STAGES-1];
        one   = UNIT_W'(fwdm_pkg::UNIT_ONE);
        qv    = $signed(UNIT_W'(last.quo));
        mag_l = last.item.l_major ? one : qv;
        mag_r = last.item.l_major ? qv : one;
        u_l   = last.item.fl[fwdm_pkg::MIX_W-1] ? -mag_l : mag_l;
        u_r   = last.item.fr[fwdm_pkg::MIX_W-1] ? -mag_r : mag_r;
        u_fl  = last.item.desat ? u_l : UNIT_W'(last.item.fl);
        u_fr  = last.item.desat ? u_r : UNIT_W'(last.item.fr);
        u_rr  = last.item.desat ? u_r : UNIT_W'(last.item.rr);
        u_rl  = last.item.desat ? u_l : UNIT_W'(last.item.rl);
    end

    // Output register: scale by max output and hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (back_en) begin
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en && r_vld[STAGES-1]) begin
            r_fl   <= scale_cmd(u_fl, i_max_output);
            r_fr   <= scale_cmd(u_fr, i_max_output);
            r_rr   <= scale_cmd(u_rr, i_max_output);
            r_rl   <= scale_cmd(u_rl, i_max_output);
            r_kind <= last.item.kind;
        end
    end

    assign o_valid = r_out_valid;
    assign o_fl    = r_fl;
    assign o_fr    = r_fr;
    assign o_rr    = r_rr;
    assign o_rl    = r_rl;
    assign o_kind  = r_kind;

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> $stable(r_vld))
        else $error("divider pipeline moved while output stalled");

    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-1] && last.item.desat && last.quo[QUO_W-1]
        |-> last.quo[QUO_W-2:0] == '0)
        else $error("desaturation quotient above full scale");

endmodule

>>> rtl/core/four_wheel_drive_mixer_unit.sv
// Path from an input beat to m_axis_tvalid: two front stages (clamp and
// deadband, then mixing), one queue slot, 15 divider stages at one quotient bit each,
// and the scaling output register.
// Throughput: one beat per cycle unless stalled; fully pipelined divider, 4-beat queue.
// Reset (synchronous, i_rst_n low): clears all valid flags and queue pointers, and loads
// arcade mode, deadband 0 and max output 12000.
module four_wheel_drive_mixer_unit #(
    parameter int AXIS_WIDTH  = fwdm_pkg::AXIS_WIDTH_DEF,
    parameter int QUEUE_DEPTH = fwdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [fwdm_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [fwdm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // strafe_axis, forward_axis, turn_axis, left_stick, right_stick (lowest first)
    input  logic [((5 * AXIS_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // front_left_cmd, front_right_cmd, rear_right_cmd, rear_left_cmd (lowest first)
    output logic [fwdm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // command_kind
    output logic                                  m_axis_tuser
);

    localparam int CMD_W = fwdm_pkg::CMD_W;
    localparam int PAD_W = fwdm_pkg::OUT_TDATA_W - fwdm_pkg::NUM_CMDS * CMD_W;

    fwdm_pkg::t_cfg      r_cfg;
    fwdm_pkg::t_mix_item push_item;
    fwdm_pkg::t_mix_item head_item;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    logic [CMD_W-1:0]    fl;
    logic [CMD_W-1:0]    fr;
    logic [CMD_W-1:0]    rr;
    logic [CMD_W-1:0]    rl;
    logic                kind;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= fwdm_pkg::MODE_ARCADE;
            r_cfg.deadband   <= fwdm_pkg::DEADBAND_RESET;
            r_cfg.max_output <= fwdm_pkg::MAX_OUT_RESET;
        end else if (i_cfg_we) begin
            case (fwdm_pkg::t_reg_idx'(i_cfg_addr))
                fwdm_pkg::REG_DRIVE_MODE: begin
                    r_cfg.mode <= fwdm_pkg::t_drive_mode'(i_cfg_data[fwdm_pkg::MODE_W-1:0]);
                end
                fwdm_pkg::REG_DEADBAND: begin
                    r_cfg.deadband <= i_cfg_data[fwdm_pkg::DEADBAND_W-1:0];
                end
                fwdm_pkg::REG_MAX_OUTPUT: begin
                    r_cfg.max_output <= i_cfg_data[fwdm_pkg::MAX_OUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    fwdm_front #(
        .AXIS_WIDTH (AXIS_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_strafe_axis  ($signed(s_axis_tdata[0 * AXIS_WIDTH +: AXIS_WIDTH])),
        .i_forward_axis ($signed(s_axis_tdata[1 * AXIS_WIDTH +: AXIS_WIDTH])),
        .i_turn_axis    ($signed(s_axis_tdata[2 * AXIS_WIDTH +: AXIS_WIDTH])),
        .i_left_stick   ($signed(s_axis_tdata[3 * AXIS_WIDTH +: AXIS_WIDTH])),
        .i_right_stick  ($signed(s_axis_tdata[4 * AXIS_WIDTH +: AXIS_WIDTH])),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    fwdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    fwdm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_output (r_cfg.max_output),
        .i_q_empty    (q_empty),
        .i_item       (head_item),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_fl         (fl),
        .o_fr         (fr),
        .o_rr         (rr),
        .o_rl         (rl),
        .o_kind       (kind)
    );

    // Pack the result beat
    assign m_axis_tdata = {{PAD_W{1'b0}}, rl, rr, fr, fl};
    assign m_axis_tuser = kind;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int AXIS_W       = fwdm_pkg::AXIS_WIDTH_DEF;
    localparam int IN_TDATA_W   = ((5 * AXIS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = fwdm_pkg::OUT_TDATA_W;
    localparam int CFG_ADDR_W   = fwdm_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W   = fwdm_pkg::CFG_DATA_W;
    localparam int NUM_CMDS     = fwdm_pkg::NUM_CMDS;
    localparam int CMD_W        = fwdm_pkg::CMD_W;
    localparam int MODE_W       = fwdm_pkg::MODE_W;
    localparam int DEADBAND_W   = fwdm_pkg::DEADBAND_W;
    localparam int MAX_OUT_W    = fwdm_pkg::MAX_OUT_W;
    localparam int UNIT_ONE     = fwdm_pkg::UNIT_ONE;
    localparam int FRAC_BITS    = fwdm_pkg::FRAC_BITS;
    localparam int PIPE_LATENCY = 18;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_ITEMS  = 108;
    localparam int LOG_CAP      = 40;

    // Index with no register behind it; writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    // One set of stick axes, laid out as on s_axis_tdata (strafe lowest)
    typedef struct packed {
        logic signed [AXIS_W-1:0] right_stick;
        logic signed [AXIS_W-1:0] left_stick;
        logic signed [AXIS_W-1:0] turn;
        logic signed [AXIS_W-1:0] forward;
        logic signed [AXIS_W-1:0] strafe;
    } t_joystick;

    // Four wheel commands, front left in cmd[0], then FR, RR, RL
    typedef struct packed {
        logic [NUM_CMDS-1:0][CMD_W-1:0] cmd;
        logic                           kind;
    } t_wheel_cmds;

    // Predict wheel commands from accepted axes and check returned beats
    class wheel_cmd_board;
        fwdm_pkg::t_drive_mode mode;
        logic [DEADBAND_W-1:0] deadband;
        logic [MAX_OUT_W-1:0]  max_out;
        t_wheel_cmds           pending [$];
        int                    errors;
        string                 wheel_tag [NUM_CMDS];

        function new();
            mode      = fwdm_pkg::MODE_ARCADE;
            deadband  = fwdm_pkg::DEADBAND_RESET;
            max_out   = fwdm_pkg::MAX_OUT_RESET;
            errors    = 0;
            wheel_tag = '{"front left", "front right", "rear right", "rear left"};
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                fwdm_pkg::REG_DRIVE_MODE: mode = fwdm_pkg::t_drive_mode'(val[MODE_W-1:0]);
                fwdm_pkg::REG_DEADBAND:   deadband = val[DEADBAND_W-1:0];
                fwdm_pkg::REG_MAX_OUTPUT: max_out = val[MAX_OUT_W-1:0];
                default: ;
            endcase
        endfunction

        function int mag(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int clamp_unit(int v);
            if (v > UNIT_ONE)
                return UNIT_ONE;
            if (v < -UNIT_ONE)
                return -UNIT_ONE;
            return v;
        endfunction

        // Clamp to +-1.0, then zero small axes where the deadband applies
        function int read_axis(logic signed [AXIS_W-1:0] raw, bit gated);
            int v;
            v = clamp_unit(int'(raw));
            if (gated && mag(v) < int'(deadband))
                return 0;
            return v;
        endfunction

        // Scale a vector pair member down by the larger magnitude, truncating
        function int shrink(int v, int peak);
            int q;
            q = (mag(v) * UNIT_ONE) / peak;
            return (v < 0) ? -q : q;
        endfunction

        // Multiply by full scale and shift right, rounding toward minus infinity
        function logic [CMD_W-1:0] scale_cmd(int u);
            longint p;
            p = longint'(u) * longint'(max_out);
            p = p >>> FRAC_BITS;
            return p[CMD_W-1:0];
        endfunction

        function t_wheel_cmds mix_wheels(t_joystick a);
            int x, y, z, l, r, m;
            int w [NUM_CMDS];
            t_wheel_cmds c;
            c.kind = fwdm_pkg::KIND_VOLTAGE;
            case (mode)
                fwdm_pkg::MODE_TANK: begin
                    l = read_axis(a.left_stick, 1'b1);
                    r = read_axis(a.right_stick, 1'b1);
                    w = '{l, r, r, l};
                end
                fwdm_pkg::MODE_ARCADE: begin
                    y = read_axis(a.forward, 1'b1);
                    z = read_axis(a.turn, 1'b1);
                    m = (mag(y) > mag(z)) ? mag(y) : mag(z);
                    if (y < 0)
                        m = -m;
                    // same quadrant signs put the maximum on the left side
                    if ((y >= 0) == (z >= 0)) begin
                        l = m;
                        r = y - z;
                    end else begin
                        l = y + z;
                        r = m;
                    end
                    l = clamp_unit(l);
                    r = clamp_unit(r);
                    w = '{l, r, r, l};
                end
                fwdm_pkg::MODE_VECTOR: begin
                    y = read_axis(a.forward, 1'b0);
                    z = read_axis(a.turn, 1'b0);
                    l = y + z;
                    r = y - z;
                    m = (mag(l) > mag(r)) ? mag(l) : mag(r);
                    if (m > UNIT_ONE) begin
                        l = shrink(l, m);
                        r = shrink(r, m);
                    end
                    w = '{l, r, r, l};
                    c.kind = fwdm_pkg::KIND_VELOCITY;
                end
                default: begin
                    x = read_axis(a.strafe, 1'b1);
                    y = read_axis(a.forward, 1'b1);
                    z = read_axis(a.turn, 1'b1);
                    w = '{clamp_unit(y + x + z), clamp_unit(y - x - z),
                          clamp_unit(y + x - z), clamp_unit(y - x + z)};
                end
            endcase
            for (int i = 0; i < NUM_CMDS; i++)
                c.cmd[i] = scale_cmd(w[i]);
            return c;
        endfunction

        task report(string what);
            // cap the log, keep counting
            if (errors < LOG_CAP)
                $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_axes(t_joystick a);
            pending.push_back(mix_wheels(a));
        endfunction

        task check_cmds(logic [OUT_TDATA_W-1:0] data, logic kind);
            t_wheel_cmds want;
            logic [CMD_W-1:0] got;
            if (pending.size() == 0) begin
                report("command beat with nothing expected");
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < NUM_CMDS; i++) begin
                got = data[i*CMD_W +: CMD_W];
                if (got !== want.cmd[i])
                    report($sformatf("%s command %0d, expected %0d", wheel_tag[i],
                                     $signed(got), $signed(want.cmd[i])));
            end
            if (kind !== want.kind)
                report($sformatf("command kind %b, expected %b", kind, want.kind));
        endtask

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    int             idle_pct      = 0;
    int             stall_pct     = 0;
    logic           sink_hold_req = 1'b0;
    logic           sink_held     = 1'b0;
    wheel_cmd_board board;

    four_wheel_drive_mixer_unit #(
        .AXIS_WIDTH (AXIS_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Note every accepted axes beat
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_axes(t_joystick'(s_axis_tdata));
    end

    // Check every accepted command beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_cmds(m_axis_tdata, m_axis_tuser);
    end

    // Stall the command side at random, or hold it off entirely
    always @(posedge i_clk) begin
        m_axis_tready <= !sink_held && ($urandom_range(99) >= stall_pct);
    end

    // Count out one long hold-off of the command side
    initial begin
        @(posedge sink_hold_req);
        sink_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_held <= 1'b0;
    end

    initial begin
        #8_000_000;
        $display("** four_wheel_drive_mixer_unit: FAILED **");
        $finish;
    end

    function automatic t_joystick make_axes(int s, int f, int t, int l, int r);
        t_joystick a;
        a.strafe      = s[AXIS_W-1:0];
        a.forward     = f[AXIS_W-1:0];
        a.turn        = t[AXIS_W-1:0];
        a.left_stick  = l[AXIS_W-1:0];
        a.right_stick = r[AXIS_W-1:0];
        return a;
    endfunction

    // Pick an axis value, biased to full scale, deadband edges and wrap values
    function automatic logic signed [AXIS_W-1:0] rand_axis(logic [DEADBAND_W-1:0] db);
        int v;
        case ($urandom_range(9))
            0, 1:    v = $urandom;
            2, 3, 4: v = int'($urandom_range(2 * UNIT_ONE)) - UNIT_ONE;
            5:       v = UNIT_ONE + int'($urandom_range(2)) - 1;
            6:       v = int'(db) + int'($urandom_range(2)) - 1;
            7: begin
                case ($urandom_range(3))
                    0:       v = 0;
                    1:       v = 32767;
                    2:       v = -32768;
                    default: v = 2 * UNIT_ONE;
                endcase
            end
            default: v = int'($urandom_range(2047)) - 1024;
        endcase
        if ($urandom_range(1))
            v = -v;
        return v[AXIS_W-1:0];
    endfunction

    function automatic t_joystick rand_axes(logic [DEADBAND_W-1:0] db);
        return make_axes(rand_axis(db), rand_axis(db), rand_axis(db),
                         rand_axis(db), rand_axis(db));
    endfunction

    // Offer one axes beat after random idle cycles; return once accepted
    task automatic feed(t_joystick a);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= a;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    // Drop valid and wait until every command has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_count() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    initial begin
        t_joystick             probes [6];
        fwdm_pkg::t_drive_mode md;
        logic [DEADBAND_W-1:0] db;
        logic [CFG_DATA_W-1:0] mx;

        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero, both rails, exact unit, zero forward with negative turn, mixed
        probes[0] = make_axes(0, 0, 0, 0, 0);
        probes[1] = make_axes(32767, 32767, 32767, 32767, 32767);
        probes[2] = make_axes(-32768, -32768, -32768, -32768, -32768);
        probes[3] = make_axes(16384, 16384, -16384, 16384, -16384);
        probes[4] = make_axes(-100, 0, -5000, -1, 1);
        probes[5] = make_axes(5000, -9000, 12000, 16385, -16385);

        // Run on the reset settings first
        feed(probes[5]);
        feed(probes[3]);
        settle();

        // Walk every mode with no deadband and the largest full scale
        write_reg(fwdm_pkg::REG_DEADBAND, '0);
        write_reg(fwdm_pkg::REG_MAX_OUTPUT, 15'd16383);
        md = md.first();
        do begin
            write_reg(fwdm_pkg::REG_DRIVE_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, md});
            foreach (probes[i])
                feed(probes[i]);
            settle();
            md = md.next();
        end while (md != md.first());

        // Random phases over modes, deadbands, full scales and idle patterns
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin md = fwdm_pkg::MODE_HOLONOMIC; db = '0;        mx = 15'd16383; end
                1: begin md = fwdm_pkg::MODE_ARCADE;    db = 15'd16384; mx = '0;        end
                2: begin md = fwdm_pkg::MODE_TANK;      db = 15'd32767; mx = 15'd12000; end
                3: begin md = fwdm_pkg::MODE_VECTOR;    db = 15'd1;     mx = 15'd1;     end
                default: begin
                    md = fwdm_pkg::t_drive_mode'(phase % 4);
                    db = ($urandom_range(3) == 0) ? DEADBAND_W'($urandom_range(32767))
                                                  : DEADBAND_W'($urandom_range(4000));
                    mx = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(32767))
                                                  : CFG_DATA_W'($urandom_range(16383));
                end
            endcase
            write_reg(fwdm_pkg::REG_DRIVE_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, md});
            write_reg(fwdm_pkg::REG_DEADBAND, db);
            write_reg(fwdm_pkg::REG_MAX_OUTPUT, mx);
            write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(32767)));

            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            // hold the command side off while beats keep streaming in
            if (phase == 4)
                sink_hold_req <= 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
                feed(rand_axes(board.deadband));
            settle();
        end

        if (board.errors == 0)
            $display("** four_wheel_drive_mixer_unit: PASSED **");
        else
            $display("** four_wheel_drive_mixer_unit: FAILED **");
        $finish;
    end

endmodule
